// ----- sv/dvrt_pkg.sv -----
// Shared types, constants and helpers of the distance-vector route table.
package dvrt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] REQ_ROUTE = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_DUMP  = 2'd2;

  localparam logic [3:0] RS_NBR       = 4'd0;
  localparam logic [3:0] RS_ADDED     = 4'd1;
  localparam logic [3:0] RS_IMPROVED  = 4'd2;
  localparam logic [3:0] RS_POISONED  = 4'd3;
  localparam logic [3:0] RS_IGNORED   = 4'd4;
  localparam logic [3:0] RS_FULL      = 4'd5;
  localparam logic [3:0] RS_TICK_DONE = 4'd6;
  localparam logic [3:0] RS_DUMP_ENT  = 4'd7;
  localparam logic [3:0] RS_EMPTY     = 4'd8;

  localparam logic CFG_ROUTE_TIMEOUT   = 1'b0;
  localparam logic CFG_GARBAGE_TIMEOUT = 1'b1;

  localparam logic [4:0]  METRIC_INF      = 5'd16;
  localparam logic [15:0] ROUTE_TMO_RST   = 16'd180;
  localparam logic [15:0] GARBAGE_TMO_RST = 16'd120;

  // One route table entry; hole marks an entry due for removal during aging.
  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] gate;
    logic [31:0] itfs;
    logic [4:0]  metric;
    logic [31:0] deadline;
    logic        hole;
  } entry_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- sv/dvrt_cell.sv -----
// One cell of the rotating table chain: holds a single entry.
module dvrt_cell
  import dvrt_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  entry_t d,
  output entry_t q
);

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ----- sv/dvrt_ctrl.sv -----
// Head controller: request sequencing, entry update at the chain head, output register.
module dvrt_ctrl
  import dvrt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    req_type,
  input  logic [31:0]   route_dest,
  input  logic [7:0]    route_metric,
  input  logic [31:0]   nbr_net,
  input  logic [31:0]   nbr_mask,
  input  logic [31:0]   nbr_gate,
  input  logic [31:0]   nbr_itfs,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata,
  input  entry_t        head,
  output entry_t        wb,
  output logic          shift_en,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [3:0]    status,
  output logic [6:0]    table_count,
  output logic [31:0]   entry_dest,
  output logic [31:0]   entry_mask,
  output logic [31:0]   entry_gate,
  output logic [31:0]   entry_itfs,
  output logic [4:0]    entry_metric,
  output logic          last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUTE = 3'd1;
  localparam logic [2:0] ST_TICK1 = 3'd2;
  localparam logic [2:0] ST_TICK2 = 3'd3;
  localparam logic [2:0] ST_DUMP  = 3'd4;
  localparam logic [2:0] ST_SEND  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rcnt_r, rcnt_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [15:0]      rt_r, gt_r;
  logic [31:0]      dst_r, net_r, mask_r, gate_r, itfs_r;
  logic [7:0]       m_r;
  logic             found_r, found_nxt;
  logic [3:0]       status_r, status_nxt;
  entry_t           hold_r, hold_nxt;
  logic             hold_v_r, hold_v_nxt;
  logic             moved_r, moved_nxt;

  logic             out_valid_r;
  logic [3:0]       out_status_r;
  logic [CNT_W-1:0] out_count_r;
  entry_t           out_ent_r;
  logic             out_last_r;

  logic             load;
  logic [3:0]       load_status;
  logic             load_ent;
  logic             load_last;

  logic [CNT_W-1:0] idx_ext;
  logic             step_in, lap_end, free_out, is_nbr, reach;
  logic [31:0]      dl_route, dl_garb;

  assign idx_ext  = CNT_W'(idx_r);
  assign step_in  = idx_ext < cnt_r;
  assign lap_end  = idx_r == IDX_W'(TABLE_DEPTH - 1);
  assign free_out = !out_valid_r || out_tready;
  assign is_nbr   = dst_r == net_r;
  assign reach    = m_r < 8'd16;
  assign dl_route = sat_add(now_r, rt_r);
  assign dl_garb  = sat_add(now_r, gt_r);
  assign in_tready = state_r == ST_IDLE;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cnt_nxt     = cnt_r;
    rcnt_nxt    = rcnt_r;
    k_nxt       = k_r;
    now_nxt     = now_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    hold_nxt    = hold_r;
    hold_v_nxt  = hold_v_r;
    moved_nxt   = moved_r;
    shift_en    = 1'b0;
    wb          = head;
    load        = 1'b0;
    load_status = status_r;
    load_ent    = 1'b0;
    load_last   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          case (req_type)
            REQ_ROUTE: begin
              status_nxt = ((route_dest == nbr_net) || (route_metric < 8'd16))
                           ? RS_FULL : RS_IGNORED;
              state_nxt  = ST_ROUTE;
            end
            REQ_TICK: begin
              if (now_r != 32'hFFFF_FFFF) begin
                now_nxt = now_r + 32'd1;
              end
              rcnt_nxt  = '0;
              state_nxt = ST_TICK1;
            end
            REQ_DUMP: begin
              status_nxt = RS_EMPTY;
              state_nxt  = (cnt_r == '0) ? ST_SEND : ST_DUMP;
            end
            default: begin
              status_nxt = RS_IGNORED;
              state_nxt  = ST_SEND;
            end
          endcase
        end
      end
      ST_ROUTE: begin
        shift_en = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
        if (step_in && !found_r && head.dest == dst_r) begin
          found_nxt = 1'b1;
          if (is_nbr) begin
            wb.metric   = '0;
            wb.deadline = dl_route;
            status_nxt  = RS_NBR;
          end else if (reach) begin
            if ((9'(m_r) + 9'd1) <= 9'(head.metric)) begin
              wb.metric   = m_r[4:0] + 5'd1;
              wb.gate     = gate_r;
              wb.itfs     = itfs_r;
              wb.deadline = dl_route;
              status_nxt  = RS_IMPROVED;
            end else begin
              status_nxt = RS_IGNORED;
            end
          end else if (head.metric < METRIC_INF) begin
            wb.metric   = METRIC_INF;
            wb.deadline = dl_garb;
            status_nxt  = RS_POISONED;
          end else begin
            status_nxt = RS_IGNORED;
          end
        end else if (idx_ext == cnt_r && !found_r && (is_nbr || reach)) begin
          // First free slot: append the new route here.
          found_nxt   = 1'b1;
          cnt_nxt     = cnt_r + CNT_W'(1);
          wb.dest     = dst_r;
          wb.gate     = gate_r;
          wb.itfs     = itfs_r;
          wb.deadline = dl_route;
          wb.hole     = 1'b0;
          if (is_nbr) begin
            wb.mask    = mask_r;
            wb.metric  = '0;
            status_nxt = RS_NBR;
          end else begin
            wb.mask    = 32'hFFFF_FFFF;
            wb.metric  = m_r[4:0] + 5'd1;
            status_nxt = RS_ADDED;
          end
        end
        if (lap_end) begin
          state_nxt = ST_SEND;
        end
      end
      ST_TICK1: begin
        shift_en = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
        wb.hole  = 1'b0;
        if (step_in && head.deadline < now_r) begin
          if (head.metric < METRIC_INF) begin
            wb.metric   = METRIC_INF;
            wb.deadline = dl_garb;
          end else begin
            wb.hole  = 1'b1;
            rcnt_nxt = rcnt_r + CNT_W'(1);
          end
        end
        if (lap_end) begin
          k_nxt      = cnt_r - rcnt_nxt;
          hold_v_nxt = 1'b0;
          moved_nxt  = 1'b0;
          state_nxt  = ST_TICK2;
        end
      end
      ST_TICK2: begin
        shift_en = 1'b1;
        idx_nxt  = idx_r + IDX_W'(1);
        if (idx_ext < k_r && head.hole && hold_v_r) begin
          wb         = hold_r;
          wb.hole    = 1'b0;
          hold_v_nxt = 1'b0;
          moved_nxt  = 1'b1;
        end else if (idx_ext >= k_r && step_in && !head.hole && !hold_v_r) begin
          hold_nxt   = head;
          hold_v_nxt = 1'b1;
          wb.hole    = 1'b1;
          moved_nxt  = 1'b1;
        end
        if (lap_end) begin
          if (moved_nxt) begin
            moved_nxt = 1'b0;
          end else begin
            cnt_nxt    = k_r;
            status_nxt = RS_TICK_DONE;
            state_nxt  = ST_SEND;
          end
        end
      end
      ST_DUMP: begin
        if (!step_in || free_out) begin
          shift_en = 1'b1;
          idx_nxt  = idx_r + IDX_W'(1);
          if (lap_end) begin
            state_nxt = ST_IDLE;
          end
        end
        if (step_in && free_out) begin
          load        = 1'b1;
          load_status = RS_DUMP_ENT;
          load_ent    = 1'b1;
          load_last   = idx_ext == (cnt_r - CNT_W'(1));
        end
      end
      ST_SEND: begin
        if (free_out) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      now_r       <= '0;
      rt_r        <= ROUTE_TMO_RST;
      gt_r        <= GARBAGE_TMO_RST;
      hold_v_r    <= 1'b0;
      moved_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      now_r    <= now_nxt;
      hold_v_r <= hold_v_nxt;
      moved_r  <= moved_nxt;
      found_r  <= found_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROUTE_TIMEOUT:   rt_r <= cfg_wdata;
          CFG_GARBAGE_TIMEOUT: gt_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rcnt_r   <= rcnt_nxt;
    k_r      <= k_nxt;
    status_r <= status_nxt;
    hold_r   <= hold_nxt;
    if (state_r == ST_IDLE && in_tvalid) begin
      dst_r  <= route_dest;
      m_r    <= route_metric;
      net_r  <= nbr_net;
      mask_r <= nbr_mask;
      gate_r <= nbr_gate;
      itfs_r <= nbr_itfs;
    end
    if (load) begin
      out_status_r <= load_status;
      out_count_r  <= cnt_nxt;
      out_last_r   <= load_last;
      out_ent_r    <= load_ent ? head : '0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign status       = out_status_r;
  assign table_count  = 7'(out_count_r);
  assign entry_dest   = out_ent_r.dest;
  assign entry_mask   = out_ent_r.mask;
  assign entry_gate   = out_ent_r.gate;
  assign entry_itfs   = out_ent_r.itfs;
  assign entry_metric = out_ent_r.metric;
  assign last         = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_dump_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && step_in && !free_out) |-> !shift_en)
    else $error("chain rotated while a dumped entry could not be sent");

  a_compact_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK2) |-> (k_r <= cnt_r))
    else $error("surviving count above entry count during compaction");

endmodule

// ----- sv/distance_vector_route_table_top.sv -----
// Top level of the distance-vector route table: cell chain and head controller.
//
// The block keeps a route table of up to TABLE_DEPTH entries, starting empty.
// Input words arrive on the in_ stream: in_tuser carries the request kind
// (route entry, one-second tick, dump), in_tdata the route and neighbour
// fields. Each result word leaves on the out_ stream with its status in
// out_tuser and out_tlast set on the final word of a request.
// The entries live in a ring of TABLE_DEPTH cells that rotates by one place
// a cycle during a lap, save while a dump pauses; the controller sees one
// entry a cycle at the head of the ring and may rewrite it on its way to the
// tail. Routes, ticks and non-empty dumps walk whole laps; an empty dump or
// an unused kind is answered at once. A route's result is sent once its lap
// ends; a dump emits one word per entry during its lap. A tick ages the table
// in a first lap, then compacts it in further laps that move surviving
// entries down into holes until a lap moves nothing. Only one request is in
// progress at a time; in_tready is high only when idle. While the receiver
// stalls, the result register holds its word and a dump lap pauses until the
// word is taken. Reset (rst_n low at a clock edge) empties the table, zeroes
// the seconds count and restores both timeouts. cfg_we writes a timeout; the
// user is to do so only while idle, as the block does not enforce it.
module distance_vector_route_table_top
  import dvrt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  // [31:0] route_dest, [39:32] route_metric, [71:40] nbr_net,
  // [103:72] nbr_mask, [135:104] nbr_gate, [167:136] nbr_itfs
  input  logic [167:0]   in_tdata,
  // [1:0] req_type
  input  logic [1:0]     in_tuser,
  output logic           out_tvalid,
  input  logic           out_tready,
  // [6:0] table_count, [38:7] entry_dest, [70:39] entry_mask,
  // [102:71] entry_gate, [134:103] entry_itfs, [139:135] entry_metric, rest zero
  output logic [143:0]   out_tdata,
  // [3:0] status
  output logic [3:0]     out_tuser,
  output logic           out_tlast,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_wdata
);

  entry_t       cell_q [TABLE_DEPTH];
  entry_t       wb;
  logic         shift_en;
  logic [6:0]   table_count;
  logic [31:0]  entry_dest, entry_mask, entry_gate, entry_itfs;
  logic [4:0]   entry_metric;

  // The ring: each cell takes its upper neighbour, the last takes the
  // controller's write-back of the head entry.
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    if (j == TABLE_DEPTH - 1) begin : g_tail
      dvrt_cell u_cell (.clk(clk), .shift_en(shift_en), .d(wb), .q(cell_q[j]));
    end else begin : g_body
      dvrt_cell u_cell (.clk(clk), .shift_en(shift_en), .d(cell_q[j+1]), .q(cell_q[j]));
    end
  end

  dvrt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .req_type     (in_tuser),
    .route_dest   (in_tdata[31:0]),
    .route_metric (in_tdata[39:32]),
    .nbr_net      (in_tdata[71:40]),
    .nbr_mask     (in_tdata[103:72]),
    .nbr_gate     (in_tdata[135:104]),
    .nbr_itfs     (in_tdata[167:136]),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .head         (cell_q[0]),
    .wb           (wb),
    .shift_en     (shift_en),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .status       (out_tuser),
    .table_count  (table_count),
    .entry_dest   (entry_dest),
    .entry_mask   (entry_mask),
    .entry_gate   (entry_gate),
    .entry_itfs   (entry_itfs),
    .entry_metric (entry_metric),
    .last         (out_tlast)
  );

  assign out_tdata = {4'b0, entry_metric, entry_itfs, entry_gate, entry_mask,
                      entry_dest, table_count};

endmodule
